// ===== rtl/bpn_pkg.sv =====
// ----------------------------------------------------------------------------
// bpn_pkg: shared types and constants for the block peak normaliser
// Beat payloads, divider handshake structs and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bpn_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int PEAK_W              = SAMPLE_W + 1;
    localparam int FRAC_BITS           = SAMPLE_W - 1;
    localparam int DEFAULT_BLOCK_DEPTH = 64;

    localparam logic signed [SAMPLE_W-1:0] Q_POS_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] Q_NEG_MAX = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_block;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] norm_value;
        logic                       last_out;
        logic                       silent_block;
    } t_out_beat;

    // Divider request: magnitude strictly below the peak
    typedef struct packed {
        logic                 start;
        logic [FRAC_BITS:0]   dividend;
        logic [PEAK_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/bpn_stream_if.sv =====
// ----------------------------------------------------------------------------
// bpn_stream_if: valid/ready stream channel
// One beat moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpn_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpn_div.sv =====
// ----------------------------------------------------------------------------
// bpn_div: fractional restoring divider
// Gives floor(dividend * 2^FRAC_BITS / divisor) for dividend < divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpn_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bpn_pkg::t_div_req i_req,
    output bpn_pkg::t_div_rsp     o_rsp
);
    localparam int PEAK_W = bpn_pkg::PEAK_W;
    localparam int FRAC_BITS = bpn_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy, n_busy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [PEAK_W-1:0]    r_rem, n_rem;
    logic [PEAK_W-1:0]    r_div, n_div;
    logic [FRAC_BITS-1:0] r_quot, n_quot;
    logic [PEAK_W:0]      w_shift;
    logic                 w_ge;
    logic                 w_fin;

    assign w_fin   = r_busy && (r_cnt == CNT_W'(FRAC_BITS));
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = PEAK_W'(i_req.dividend);
            n_div  = i_req.divisor;
        end else if (w_fin) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            // one restoring step: shift, trial subtract, shift in quotient bit
            n_rem  = w_ge ? PEAK_W'(w_shift - {1'b0, r_div}) : PEAK_W'(w_shift);
            n_quot = {r_quot[FRAC_BITS-2:0], w_ge};
            n_cnt  = CNT_W'(r_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_rsp.done = w_fin;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/block_peak_normaliser.sv =====
// ----------------------------------------------------------------------------
// block_peak_normaliser: block store with peak normalization
// Stores a block of signed samples, then emits each one scaled by the block
// peak magnitude as Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  (sink) carries one sample beat with end_of_block. Beats load one per
//   cycle into a BLOCK_DEPTH entry store while the peak magnitude is tracked.
//   A block closes on the beat with end_of_block set or on the beat that fills
//   the store; input is then held off until the whole block has been sent.
//   o_out (source) carries one beat per stored sample, in order, with
//   last_out on the final one and silent_block on every beat of a block whose
//   peak is zero (those values are zero).
//   Each result reads the store, prepares, runs the 15-step fractional
//   divider until its done flag and loads the output register; results of a
//   silent block and samples equal to the peak skip the divider.
//   Reset clears the fill count, peak and control; store contents stay.
//   A stalled receiver holds the output register and the sequencer waits;
//   a new block is accepted while the last beat still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module block_peak_normaliser #(
    parameter int BLOCK_DEPTH = bpn_pkg::DEFAULT_BLOCK_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bpn_stream_if.sink   i_in,
    bpn_stream_if.source o_out
);
    localparam int SAMPLE_W  = bpn_pkg::SAMPLE_W;
    localparam int PEAK_W    = bpn_pkg::PEAK_W;
    localparam int FRAC_BITS = bpn_pkg::FRAC_BITS;
    localparam int ADDR_W    = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BLOCK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_READ = 5'b00010,
        S_CALC = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [PEAK_W-1:0]    r_peak, n_peak;
    logic signed [SAMPLE_W-1:0] r_val, n_val;
    logic                 r_out_valid, n_out_valid;
    bpn_pkg::t_out_beat   r_out, n_out;

    // sample store, one write port and one registered read port
    logic signed [SAMPLE_W-1:0] r_store [BLOCK_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    bpn_pkg::t_in_beat    w_in;
    logic                 w_in_acc;
    logic [CNT_W-1:0]     w_fill_inc;
    logic                 w_close;
    logic [PEAK_W-1:0]    w_in_mag;
    logic [PEAK_W-1:0]    w_rd_mag;
    logic                 w_silent;
    logic                 w_full_scale;
    logic                 w_last;
    logic                 w_out_free;
    bpn_pkg::t_div_req    w_div_req;
    bpn_pkg::t_div_rsp    w_div_rsp;

    function automatic logic [PEAK_W-1:0] f_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [PEAK_W-1:0] ext;
        ext = {s[SAMPLE_W-1], s};
        return s[SAMPLE_W-1] ? PEAK_W'({PEAK_W{1'b0}} - ext) : ext;
    endfunction

    assign w_in       = i_in.payload;
    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_fill_inc = CNT_W'(r_fill + 1'b1);
    assign w_close    = w_in.end_of_block || (w_fill_inc == CNT_W'(BLOCK_DEPTH));
    assign w_in_mag   = f_mag(w_in.sample);

    assign w_rd_mag     = f_mag(r_rd_data);
    assign w_silent     = (r_peak == '0);
    assign w_full_scale = (w_rd_mag == r_peak);
    assign w_last       = (CNT_W'(r_idx + 1'b1) == r_fill);
    assign w_out_free   = !r_out_valid || o_out.ready;

    // hand the divider only magnitudes strictly below the peak
    assign w_div_req.start    = (r_state == S_CALC) && !w_silent && !w_full_scale;
    assign w_div_req.dividend = w_rd_mag[FRAC_BITS:0];
    assign w_div_req.divisor  = r_peak;

    bpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_peak      = r_peak;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // drop the output beat once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    n_fill = w_fill_inc;
                    if (w_in_mag > r_peak) begin
                        n_peak = w_in_mag;
                    end
                    if (w_close) begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // read issued at this edge, data valid in S_CALC
                n_state = S_CALC;
            end
            S_CALC: begin
                if (w_silent) begin
                    n_val   = '0;
                    n_state = S_PUT;
                end else if (w_full_scale) begin
                    n_val   = r_rd_data[SAMPLE_W-1] ? bpn_pkg::Q_NEG_MAX
                                                    : bpn_pkg::Q_POS_MAX;
                    n_state = S_PUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    // truncation toward zero: negate the magnitude quotient
                    n_val   = r_rd_data[SAMPLE_W-1]
                              ? SAMPLE_W'({SAMPLE_W{1'b0}} - {1'b0, w_div_rsp.quot})
                              : SAMPLE_W'({1'b0, w_div_rsp.quot});
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.norm_value   = r_val;
                    n_out.last_out     = w_last;
                    n_out.silent_block = w_silent;
                    if (w_last) begin
                        n_fill  = '0;
                        n_peak  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = CNT_W'(r_idx + 1'b1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_idx       <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
        end
        r_val <= n_val;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_store[r_fill[ADDR_W-1:0]] <= w_in.sample;
        end
        r_rd_data <= r_store[r_idx[ADDR_W-1:0]];
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(BLOCK_DEPTH))
        else $error("fill count beyond block depth");

    a_close_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_close) |=> (r_state == S_READ))
        else $error("closing beat did not start readout");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.silent_block) |-> (r_out.norm_value == '0))
        else $error("silent block beat carries nonzero value");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for block_peak_normaliser
// Drives sample beats with random gaps, takes result beats with random stalls,
// and checks every result against a block-level peak normalization predictor.
// A table of directed beats comes first, then random blocks of mixed content.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int SAMPLE_W    = bpn_pkg::SAMPLE_W;
    localparam int DEPTH       = bpn_pkg::DEFAULT_BLOCK_DEPTH;
    localparam int RAND_ITEMS  = 105;   // plus the directed rows, about 130 beats
    localparam int STALL_LIMIT = 1000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES = 60;    // idle time after the final drain

    // One stimulus row. When pinned is set, the result for this sample is the
    // typed-in norm/silent pair instead of the predictor's value.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       eob;
        logic                       pinned;
        logic signed [SAMPLE_W-1:0] norm;
        logic                       silent;
    } t_stim_row;

    typedef enum int {FILL_SILENT, FILL_TINY, FILL_EXTREME, FILL_WIDE} t_fill_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpn_stream_if #(.t_payload(bpn_pkg::t_in_beat))  in_ch  ();
    bpn_stream_if #(.t_payload(bpn_pkg::t_out_beat)) out_ch ();

    block_peak_normaliser #(
        .BLOCK_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: samples of the block being filled and its peak.
    t_stim_row          open_block [$];
    t_stim_row          sent_rows [$];     // rows in flight on the input, oldest first
    bpn_pkg::t_out_beat pending_norm [$];  // results still owed by the block
    int                 peak_mag  = 0;
    int                 err_count = 0;
    int                 idle_cycles = 0;

    // Directed beats: extremes, full-scale saturation, silent blocks and a few
    // mixed blocks. Each block closes on the row with eob set.
    t_stim_row directed_rows [0:20] = '{
        // positive full scale alone: +1.0 saturates
        '{16'sd32767,   1'b1, 1'b1, bpn_pkg::Q_POS_MAX, 1'b0},
        // most negative sample alone: peak 32768, exactly -1.0
        '{16'sh8000,    1'b1, 1'b1, bpn_pkg::Q_NEG_MAX, 1'b0},
        // silent blocks, one beat and three beats
        '{16'sd0,       1'b1, 1'b1, 16'sd0,             1'b1},
        '{16'sd0,       1'b0, 1'b1, 16'sd0,             1'b1},
        '{16'sd0,       1'b0, 1'b1, 16'sd0,             1'b1},
        '{16'sd0,       1'b1, 1'b1, 16'sd0,             1'b1},
        // peak 32768 from the negative extreme
        '{16'sd16384,   1'b0, 1'b1, 16'sd16384,         1'b0},
        '{16'sh8000,    1'b1, 1'b1, bpn_pkg::Q_NEG_MAX, 1'b0},
        // peak 100 reached on both signs
        '{16'sd100,     1'b0, 1'b1, bpn_pkg::Q_POS_MAX, 1'b0},
        '{-16'sd50,     1'b0, 1'b1, -16'sd16384,        1'b0},
        '{16'sd1,       1'b0, 1'b1, 16'sd327,           1'b0},
        '{-16'sd100,    1'b1, 1'b1, bpn_pkg::Q_NEG_MAX, 1'b0},
        // peak 32767
        '{16'sd32767,   1'b0, 1'b1, bpn_pkg::Q_POS_MAX, 1'b0},
        '{-16'sd32767,  1'b0, 1'b1, bpn_pkg::Q_NEG_MAX, 1'b0},
        '{16'sd1,       1'b1, 1'b1, 16'sd1,             1'b0},
        // peak 1
        '{-16'sd1,      1'b0, 1'b1, bpn_pkg::Q_NEG_MAX, 1'b0},
        '{16'sd0,       1'b0, 1'b1, 16'sd0,             1'b0},
        '{16'sd1,       1'b1, 1'b1, bpn_pkg::Q_POS_MAX, 1'b0},
        // left to the predictor
        '{16'sd12345,   1'b0, 1'b0, 16'sd0,             1'b0},
        '{-16'sd23456,  1'b0, 1'b0, 16'sd0,             1'b0},
        '{16'sd7,       1'b1, 1'b0, 16'sd0,             1'b0}
    };

    // trunc(sample * 32768 / peak), saturated to Q1.15
    function automatic logic signed [SAMPLE_W-1:0] scale_to_peak(input int sv,
                                                                 input int peak);
        longint q;
        q = (longint'(sv) * 64'sd32768) / longint'(peak);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // Add one accepted sample to the open block; on block close, queue
    // one expected result per stored sample and clear the block.
    function automatic void absorb_sample(input bpn_pkg::t_in_beat beat,
                                          input t_stim_row row);
        int                 sv;
        int                 mag;
        bpn_pkg::t_out_beat res;
        sv  = int'($signed(beat.sample));
        mag = (sv < 0) ? -sv : sv;
        if (mag > peak_mag)
            peak_mag = mag;
        row.sample = beat.sample;
        open_block = {open_block, row};
        if (beat.end_of_block || open_block.size() == DEPTH) begin
            foreach (open_block[k]) begin
                res.last_out     = (k == open_block.size() - 1);
                res.silent_block = (peak_mag == 0);
                res.norm_value   = (peak_mag == 0) ? '0
                                   : scale_to_peak(int'($signed(open_block[k].sample)), peak_mag);
                if (open_block[k].pinned) begin
                    res.norm_value   = open_block[k].norm;
                    res.silent_block = open_block[k].silent;
                end
                pending_norm = {pending_norm, res};
            end
            open_block.delete();
            peak_mag = 0;
        end
    endfunction

    // Check result beats first, then feed the predictor, so a block closing
    // on the same edge as an older result lands behind it in the queue.
    always @(posedge i_clk) begin : scoreboard
        bpn_pkg::t_out_beat want;
        bpn_pkg::t_out_beat got;
        t_stim_row          row;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (pending_norm.size() == 0) begin
                    $display("%0t: unexpected result beat norm_value %0d", $time,
                             $signed(got.norm_value));
                    err_count++;
                end else begin
                    want = pending_norm.pop_front();
                    if (got.norm_value !== want.norm_value) begin
                        $display("%0t: norm_value expected %0d actual %0d", $time,
                                 $signed(want.norm_value), $signed(got.norm_value));
                        err_count++;
                    end
                    if (got.last_out !== want.last_out) begin
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 want.last_out, got.last_out);
                        err_count++;
                    end
                    if (got.silent_block !== want.silent_block) begin
                        $display("%0t: silent_block expected %0b actual %0b", $time,
                                 want.silent_block, got.silent_block);
                        err_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                row = sent_rows.pop_front();
                absorb_sample(in_ch.payload, row);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: drop ready for a random stall before each beat, with bursts of
    // back-to-back acceptance now and then.
    initial begin : receiver
        int stall;
        int burst_left;
        burst_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (burst_left > 0) begin
                stall = 0;
                burst_left--;
            end else if ($urandom_range(0, 15) == 0) begin
                stall = 0;
                burst_left = $urandom_range(8, 24);
            end else begin
                stall = $urandom_range(0, 10);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1)
                @(posedge i_clk);
        end
    end

    // Present one sample beat after a gap and hold it until it is taken.
    // Valid stays high afterwards; the next call drops it only for a gap.
    task automatic drive_beat(input t_stim_row row, input int gap);
        bpn_pkg::t_in_beat beat;
        beat.sample       = row.sample;
        beat.end_of_block = row.eob;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sent_rows = {sent_rows, row};
        in_ch.valid   <= 1'b1;
        in_ch.payload <= beat;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
    endtask

    // Hold until the predictor owes nothing; the first edge lets a block
    // closed on the current edge reach the queue.
    task automatic wait_for_drain();
        @(posedge i_clk);
        while (pending_norm.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_stim_row  row;
        t_fill_mode mode;
        int         blk;
        int         sent;
        int         len;
        int         pick;
        bit         full;
        bit         burst;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_beat(directed_rows[i], $urandom_range(0, 10));

        // hold off new samples until the directed blocks are all out
        in_ch.valid <= 1'b0;
        wait_for_drain();

        // Random blocks: mostly short, some longer, one that only ends by
        // filling the store.
        blk  = 0;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            full = (blk == 2);
            if (full)
                len = DEPTH;
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(1, 8);
            pick = $urandom_range(0, 7);
            case (pick)
                0:       mode = FILL_SILENT;
                1:       mode = FILL_TINY;
                2:       mode = FILL_EXTREME;
                default: mode = FILL_WIDE;
            endcase
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                row = '0;
                case (mode)
                    FILL_SILENT:  row.sample = '0;
                    FILL_TINY:    row.sample = SAMPLE_W'($urandom_range(0, 6) - 3);
                    FILL_EXTREME: begin
                        case ($urandom_range(0, 3))
                            0:       row.sample = bpn_pkg::Q_NEG_MAX;
                            1:       row.sample = bpn_pkg::Q_POS_MAX;
                            2:       row.sample = -16'sd32767;
                            default: row.sample = SAMPLE_W'($urandom());
                        endcase
                    end
                    default:      row.sample = SAMPLE_W'($urandom());
                endcase
                row.eob = !full && (k == len - 1);
                drive_beat(row, burst ? 0 : $urandom_range(0, 10));
            end
            sent += len;
            blk++;
            if (blk == 5) begin
                in_ch.valid <= 1'b0;
                wait_for_drain();
            end
        end

        in_ch.valid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_norm.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_norm.size());
            err_count++;
        end
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
